/* sv/wav_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared types, tags, error codes and controller states.
// ----------------------------------------------------------------------------
package wav_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	localparam logic [15:0] FMT_PCM   = 16'h0001;
	localparam logic [15:0] FMT_FLOAT = 16'h0003;
	localparam logic [15:0] FMT_ALAW  = 16'h0006;
	localparam logic [15:0] FMT_MULAW = 16'h0007;
	localparam logic [15:0] FMT_EXT   = 16'hFFFE;

	typedef enum logic [3:0] {
		ERR_OK           = 4'd0,
		ERR_SHORT_RIFF   = 4'd1,
		ERR_RIFF_ID      = 4'd2,
		ERR_WAVE_ID      = 4'd3,
		ERR_SHORT_FMT    = 4'd4,
		ERR_FMT_MISSING  = 4'd5,
		ERR_FMT_SIZE     = 4'd6,
		ERR_TAG          = 4'd7,
		ERR_SHORT_DATA   = 4'd8,
		ERR_DATA_MISSING = 4'd9,
		ERR_MISALIGNED   = 4'd10
	} err_t;

	typedef enum logic [1:0] {
		ST_SCAN,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       is_final;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  error_code;
		logic [31:0] riff_size;
		logic [31:0] fmt_size;
		logic [15:0] format_tag;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
		logic [15:0] sample_bits;
		logic [31:0] data_size;
		logic [31:0] frame_count;
		logic [31:0] sample_offset;
	} out_item_t;

	// Controller to datapath.
	typedef struct packed {
		logic take_byte;
		logic div_start;
		logic div_step;
		logic clear;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic div_needed;
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

/* sv/wav_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser controller
// Sequences byte scanning, the frame division and result hand-off.
// ----------------------------------------------------------------------------
module wav_ctrl import wav_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	input  wire  in_final,
	output logic in_ready,
	output logic out_valid,
	input  wire  out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SCAN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_SCAN: begin
				if (in_valid && in_final) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!sts.div_needed || sts.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_SCAN;
				end
			end
			default: state_d = ST_SCAN;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		cmd.take_byte = 1'b0;
		cmd.div_start = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.clear     = 1'b0;
		case (state_q)
			ST_SCAN: begin
				in_ready      = 1'b1;
				cmd.take_byte = in_valid;
				cmd.div_start = in_valid && in_final;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				cmd.clear = out_ready;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* sv/wav_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser datapath
// Tag window, field capture, final checks and a radix-2 frame divider.
// ----------------------------------------------------------------------------
module wav_dpath import wav_pkg::*; #(
	parameter int POSITION_BITS = 32
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire [7:0] file_byte,
	input  cmd_t      cmd,
	output sts_t      sts,
	output out_item_t result
);

	localparam int PB = POSITION_BITS;

	logic [PB-1:0] pos_q;
	logic [31:0]   win_q;
	logic          riff_ok_q, wave_ok_q;
	logic          fmt_seen_q, data_seen_q;
	logic [PB-1:0] fmt_start_q, data_start_q;
	logic [31:0]   riff_size_q, fmt_size_q, rate_q, brate_q, dsize_q;
	logic [15:0]   ftag_q, chans_q, align_q, bits_q;
	logic [3:0]    err_q;
	logic [31:0]   quo_q, rem_q;
	logic [5:0]    cnt_q;

	logic [31:0]   win_d;
	logic [PB-1:0] foff, doff, size_next;
	logic          fmt_hit, data_hit, fmt_now, data_now;
	logic [PB-1:0] fstart_now, dstart_now;
	logic [3:0]    err_pre;
	logic          tag_good;
	logic [32:0]   rem_shift;

	assign win_d = {win_q[23:0], file_byte};
	assign fmt_hit  = (pos_q >= PB'(3)) && !fmt_seen_q && (win_d == TAG_FMT);
	assign data_hit = (pos_q >= PB'(3)) && !data_seen_q && (win_d == TAG_DATA);
	assign fmt_now    = fmt_seen_q || fmt_hit;
	assign data_now   = data_seen_q || data_hit;
	assign fstart_now = fmt_hit ? pos_q - PB'(3) : fmt_start_q;
	assign dstart_now = data_hit ? pos_q - PB'(3) : data_start_q;
	assign foff = pos_q - fstart_now;
	assign doff = pos_q - dstart_now;
	assign size_next = (&pos_q) ? pos_q : pos_q + PB'(1);

	assign tag_good = (ftag_q == FMT_PCM) || (ftag_q == FMT_FLOAT) ||
		(ftag_q == FMT_ALAW) || (ftag_q == FMT_MULAW) || (ftag_q == FMT_EXT);

	// Checks up to the data-size ones, using state after the final byte.
	// Field bytes on the final byte are not yet in the field registers, but
	// the only checks that use fields are evaluated in the following cycle.
	always_comb begin
		if (size_next < PB'(12))                        err_pre = ERR_SHORT_RIFF;
		else if (!riff_ok_q)                            err_pre = ERR_RIFF_ID;
		else if (!(wave_ok_q || (pos_q == PB'(11) && win_d == TAG_WAVE)))
			err_pre = ERR_WAVE_ID;
		else if (size_next < PB'(24))                   err_pre = ERR_SHORT_FMT;
		else if (!fmt_now)                              err_pre = ERR_FMT_MISSING;
		else if (size_next - fstart_now < PB'(24))      err_pre = ERR_SHORT_FMT;
		else                                            err_pre = ERR_OK;
	end

	// Second-stage checks: err_q holds early result or ERR_OK pending.
	logic [3:0] err_fin;
	logic       size_ok_d;
	logic       dshort_q;
	always_comb begin
		if (err_q != ERR_OK)             err_fin = err_q;
		else if (fmt_size_q < 32'd16)    err_fin = ERR_FMT_SIZE;
		else if (!tag_good)              err_fin = ERR_TAG;
		else if (!data_seen_q)           err_fin = ERR_DATA_MISSING;
		else if (dshort_q)               err_fin = ERR_SHORT_DATA;
		else if (align_q == 16'd0)       err_fin = ERR_MISALIGNED;
		else                             err_fin = ERR_OK;
	end
	assign size_ok_d = (size_next - dstart_now) < PB'(8);

	assign sts.div_needed = (err_fin == ERR_OK);
	assign sts.div_done   = cnt_q[5];
	assign rem_shift = {rem_q, quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			win_q <= '0;
			riff_ok_q <= 1'b0;
			wave_ok_q <= 1'b0;
			fmt_seen_q <= 1'b0;
			data_seen_q <= 1'b0;
			fmt_start_q <= '0;
			data_start_q <= '0;
			riff_size_q <= '0;
			fmt_size_q <= '0;
			ftag_q <= '0;
			chans_q <= '0;
			rate_q <= '0;
			brate_q <= '0;
			align_q <= '0;
			bits_q <= '0;
			dsize_q <= '0;
			err_q <= ERR_OK;
			dshort_q <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.clear) begin
			pos_q <= '0;
			win_q <= '0;
			riff_ok_q <= 1'b0;
			wave_ok_q <= 1'b0;
			fmt_seen_q <= 1'b0;
			data_seen_q <= 1'b0;
			fmt_start_q <= '0;
			data_start_q <= '0;
			riff_size_q <= '0;
			fmt_size_q <= '0;
			ftag_q <= '0;
			chans_q <= '0;
			rate_q <= '0;
			brate_q <= '0;
			align_q <= '0;
			bits_q <= '0;
			dsize_q <= '0;
			err_q <= ERR_OK;
			dshort_q <= 1'b0;
			quo_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.take_byte) begin
			win_q <= win_d;
			pos_q <= size_next;
			if (pos_q == PB'(3) && win_d == TAG_RIFF) riff_ok_q <= 1'b1;
			if (pos_q == PB'(11) && win_d == TAG_WAVE) wave_ok_q <= 1'b1;
			if (fmt_hit) begin
				fmt_seen_q <= 1'b1;
				fmt_start_q <= pos_q - PB'(3);
			end
			if (data_hit) begin
				data_seen_q <= 1'b1;
				data_start_q <= pos_q - PB'(3);
			end
			if (pos_q >= PB'(4) && pos_q <= PB'(7))
				riff_size_q[8*pos_q[1:0] +: 8] <= file_byte;
			if (fmt_now && pos_q >= fstart_now) begin
				if (foff >= PB'(4) && foff <= PB'(7))
					fmt_size_q[8*foff[1:0] +: 8] <= file_byte;
				else if (foff >= PB'(8) && foff <= PB'(9))
					ftag_q[8*foff[0] +: 8] <= file_byte;
				else if (foff >= PB'(10) && foff <= PB'(11))
					chans_q[8*foff[0] +: 8] <= file_byte;
				else if (foff >= PB'(12) && foff <= PB'(15))
					rate_q[8*foff[1:0] +: 8] <= file_byte;
				else if (foff >= PB'(16) && foff <= PB'(19))
					brate_q[8*foff[1:0] +: 8] <= file_byte;
				else if (foff >= PB'(20) && foff <= PB'(21))
					align_q[8*foff[0] +: 8] <= file_byte;
				else if (foff >= PB'(22) && foff <= PB'(23))
					bits_q[8*foff[0] +: 8] <= file_byte;
			end
			if (data_now && pos_q >= dstart_now && doff >= PB'(4) && doff <= PB'(7))
				dsize_q[8*doff[1:0] +: 8] <= file_byte;
			if (cmd.div_start) begin
				err_q <= err_pre;
				dshort_q <= size_ok_d;
				cnt_q <= '0;
			end
		end else if (cmd.div_step) begin
			if (cnt_q == 6'd0) begin
				err_q <= err_fin;
				quo_q <= dsize_q;
				rem_q <= '0;
				cnt_q <= 6'd1;
			end else if (!cnt_q[5] || cnt_q == 6'd32) begin
				// One quotient bit per cycle, restoring division.
				if (rem_shift >= {17'd0, align_q}) begin
					rem_q <= 32'(rem_shift - {17'd0, align_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_shift[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	// cnt_q counts the steps 1..32. Done shows while the 32nd step is being
	// taken, so the controller leaves just as that step completes.
	logic div_ok;
	assign div_ok = (err_q == ERR_OK) && (rem_q == 32'd0);

	always_comb begin
		result.error_code    = (err_q == ERR_OK && rem_q != 32'd0) ? ERR_MISALIGNED : err_q;
		result.riff_size     = riff_size_q;
		result.fmt_size      = fmt_size_q;
		result.format_tag    = ftag_q;
		result.channel_count = chans_q;
		result.sample_rate   = rate_q;
		result.byte_rate     = brate_q;
		result.block_align   = align_q;
		result.sample_bits   = bits_q;
		result.data_size     = dsize_q;
		result.frame_count   = div_ok ? quo_q : 32'd0;
		result.sample_offset = data_seen_q ? 32'(data_start_q) + 32'd8 : 32'd0;
	end

endmodule
`default_nettype wire

/* sv/wav_header_parser_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// WAV header parser
// Scans a WAV file byte stream and reports header fields and an error code.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while scanning. After the byte marked final,
// the block finishes the checks and then, when they pass, runs a bit-serial
// divider computing the frame count before the result is offered; it then
// waits on out until taken, and the next file's first byte is accepted in
// the cycle after that transaction.
module wav_header_parser_unit import wav_pkg::*; #(
	parameter int POSITION_BITS = 32
) (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  wire       out_ready,
	output out_item_t out_data
);

	cmd_t cmd;
	sts_t sts;

	wav_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_final (in_data.is_final),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wav_dpath #(.POSITION_BITS(POSITION_BITS)) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.file_byte(in_data.file_byte),
		.cmd      (cmd),
		.sts      (sts),
		.result   (out_data)
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output open together");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_final_leaves_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.is_final |=> !in_ready)
		else $error("scan continued after final byte");
`endif

endmodule
`default_nettype wire
